// File: design/calendar_clock_counter_macros.svh
// assertion macros for the calendar clock counter
`ifndef CALENDAR_CLOCK_COUNTER_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_MACROS_SVH

// same-cycle implication, quiet during reset
`define CCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define CCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/cal_clk_pkg.sv
// types, constants and calendar helper functions for the calendar clock counter
package cal_clk_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int FUNC_W   = 2;
   localparam int SEL_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [YEAR_W-1:0]   YEAR_MAX    = 14'd9999;
   localparam logic [MONTH_W-1:0]  MONTH_LAST  = 4'd12;
   localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0]  MONTH_APR   = 4'd4;
   localparam logic [MONTH_W-1:0]  MONTH_JUN   = 4'd6;
   localparam logic [MONTH_W-1:0]  MONTH_SEP   = 4'd9;
   localparam logic [MONTH_W-1:0]  MONTH_NOV   = 4'd11;
   localparam logic [DAY_W-1:0]    DAY_LAST    = 5'd31;
   localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
   localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
   localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;

   // divisibility by 25 through a scaled reciprocal
   localparam int DIV25_SHIFT = 19;
   localparam int DIV25_MULT  = ((1 << DIV25_SHIFT) + 24) / 25;
   localparam int DIV25_PROD_W = YEAR_W + 15;

   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

   localparam logic [SEL_W-1:0] SEL_DAY    = 3'd0;
   localparam logic [SEL_W-1:0] SEL_MONTH  = 3'd1;
   localparam logic [SEL_W-1:0] SEL_YEAR   = 3'd2;
   localparam logic [SEL_W-1:0] SEL_HOUR   = 3'd3;
   localparam logic [SEL_W-1:0] SEL_MINUTE = 3'd4;
   localparam logic [SEL_W-1:0] SEL_SECOND = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_YEAR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MONTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_DAY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HOUR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MINUTE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SECOND = 3'd5;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [SEL_W-1:0]    field_sel;
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } req_item_type;

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [DIV25_PROD_W-1:0] prod;
      logic                    div25;
      prod  = DIV25_PROD_W'(y) * DIV25_PROD_W'(DIV25_MULT);
      div25 = prod[DIV25_SHIFT-1:0] < DIV25_SHIFT'(DIV25_MULT);
      return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic [YEAR_W-1:0] y);
      logic [DAY_W-1:0] len;
      if (m == MONTH_FEB) begin
         len = is_leap(y) ? 5'd29 : 5'd28;
      end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         len = 5'd30;
      end else begin
         len = DAY_LAST;
      end
      return len;
   endfunction

   function automatic logic date_ok(input logic [DAY_W-1:0] d,
                                    input logic [MONTH_W-1:0] m,
                                    input logic [YEAR_W-1:0] y);
      return (m >= 4'd1) && (m <= MONTH_LAST) && (y <= YEAR_MAX) &&
             (d >= 5'd1) && (d <= month_len(m, y));
   endfunction

   function automatic logic time_ok(input logic [HOUR_W-1:0] h,
                                    input logic [MINUTE_W-1:0] mi,
                                    input logic [SECOND_W-1:0] s);
      return (h <= HOUR_LAST) && (mi <= MINUTE_LAST) && (s <= SECOND_LAST);
   endfunction

endpackage

// File: design/cal_clk_ifs.sv
// request and response channel interfaces for the calendar clock counter
interface cal_clk_req_if import cal_clk_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SEL_W-1:0]    field_sel;
   logic [DAY_W-1:0]    day_in;
   logic [MONTH_W-1:0]  month_in;
   logic [YEAR_W-1:0]   year_in;
   logic [HOUR_W-1:0]   hour_in;
   logic [MINUTE_W-1:0] minute_in;
   logic [SECOND_W-1:0] second_in;

   modport source (output valid, func, field_sel, day_in, month_in, year_in, hour_in,
                   minute_in, second_in, input ready);
   modport sink (input valid, func, field_sel, day_in, month_in, year_in, hour_in,
                 minute_in, second_in, output ready);
endinterface

interface cal_clk_rsp_if import cal_clk_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DAY_W-1:0]    day_out;
   logic [MONTH_W-1:0]  month_out;
   logic [YEAR_W-1:0]   year_out;
   logic [HOUR_W-1:0]   hour_out;
   logic [MINUTE_W-1:0] minute_out;
   logic [SECOND_W-1:0] second_out;
   logic                time_valid;
   logic                step_ok;
   logic                after_target;
   logic                equal_target;

   modport source (output valid, day_out, month_out, year_out, hour_out, minute_out,
                   second_out, time_valid, step_ok, after_target, equal_target,
                   input ready);
   modport sink (input valid, day_out, month_out, year_out, hour_out, minute_out,
                 second_out, time_valid, step_ok, after_target, equal_target,
                 output ready);
endinterface

// File: design/calendar_clock_counter.sv
// calendar clock counter: second-resolution Gregorian clock with target compare
//
// usage:
//   req_if carries one command per transfer: tick one second, load a full
//   date and time, or write a single field. rsp_if returns one response per
//   command with the clock after the command, its valid flag, whether the
//   command took effect, and its order against the target time.
//   csr_we/csr_index/csr_wdata set the six target fields; write them only
//   while no command is in flight.
//   a command is captured in the request register and applied once the
//   response register is free, which also registers its response. the
//   clock registers take one command per cycle while rsp_if.ready stays
//   high, set by the single update pass of the clock registers; the
//   request register takes one more command while a response waits.
//   reset clears the clock to all zero and invalid, sets the target to
//   0000-01-01 00:00:00 and empties both registers.
//   when rsp_if.ready is low the response holds, the captured command waits,
//   and req_if.ready drops once the request register is full.
`include "calendar_clock_counter_macros.svh"

module calendar_clock_counter import cal_clk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   cal_clk_req_if.sink           req_if,
   cal_clk_rsp_if.source         rsp_if
);

   logic [YEAR_W-1:0]   tgt_year_ff;
   logic [MONTH_W-1:0]  tgt_month_ff;
   logic [DAY_W-1:0]    tgt_day_ff;
   logic [HOUR_W-1:0]   tgt_hour_ff;
   logic [MINUTE_W-1:0] tgt_minute_ff;
   logic [SECOND_W-1:0] tgt_second_ff;

   logic                in_valid_ff;
   req_item_type        in_item_ff;
   req_item_type        req_item;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff;

   logic [YEAR_W-1:0]   cur_year_ff, cur_year_in;
   logic [MONTH_W-1:0]  cur_month_ff, cur_month_in;
   logic [DAY_W-1:0]    cur_day_ff, cur_day_in;
   logic [HOUR_W-1:0]   cur_hour_ff, cur_hour_in;
   logic [MINUTE_W-1:0] cur_minute_ff, cur_minute_in;
   logic [SECOND_W-1:0] cur_second_ff, cur_second_in;
   logic                clock_valid_ff, clock_valid_in;
   logic                step_ok;

   logic                out_free;
   logic                fire;
   logic                at_end;
   logic [DAY_W-1:0]    cur_len;
   logic                load_ok;
   logic [39:0]         cur_key;
   logic [39:0]         tgt_key;

   // handshake
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign fire         = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || fire;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_if.ready);

   assign req_item = '{func: req_if.func, field_sel: req_if.field_sel,
                       day: req_if.day_in, month: req_if.month_in,
                       year: req_if.year_in, hour: req_if.hour_in,
                       minute: req_if.minute_in, second: req_if.second_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_year_ff   <= '0;
         tgt_month_ff  <= 4'd1;
         tgt_day_ff    <= 5'd1;
         tgt_hour_ff   <= '0;
         tgt_minute_ff <= '0;
         tgt_second_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_YEAR:   tgt_year_ff   <= csr_wdata[YEAR_W-1:0];
            CSR_TARGET_MONTH:  tgt_month_ff  <= csr_wdata[MONTH_W-1:0];
            CSR_TARGET_DAY:    tgt_day_ff    <= csr_wdata[DAY_W-1:0];
            CSR_TARGET_HOUR:   tgt_hour_ff   <= csr_wdata[HOUR_W-1:0];
            CSR_TARGET_MINUTE: tgt_minute_ff <= csr_wdata[MINUTE_W-1:0];
            CSR_TARGET_SECOND: tgt_second_ff <= csr_wdata[SECOND_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_item_ff <= req_item;
      end
      if (fire) begin
         rsp_ok_ff <= step_ok;
      end
   end

   // next clock value for the command in the request register
   assign at_end = (cur_year_ff >= YEAR_MAX) && (cur_month_ff == MONTH_LAST) &&
                   (cur_day_ff == DAY_LAST) && (cur_hour_ff == HOUR_LAST) &&
                   (cur_minute_ff == MINUTE_LAST) && (cur_second_ff == SECOND_LAST);
   assign cur_len = month_len(cur_month_ff, cur_year_ff);
   assign load_ok = date_ok(in_item_ff.day, in_item_ff.month, in_item_ff.year) &&
                    time_ok(in_item_ff.hour, in_item_ff.minute, in_item_ff.second);

   always_comb begin
      cur_year_in    = cur_year_ff;
      cur_month_in   = cur_month_ff;
      cur_day_in     = cur_day_ff;
      cur_hour_in    = cur_hour_ff;
      cur_minute_in  = cur_minute_ff;
      cur_second_in  = cur_second_ff;
      clock_valid_in = clock_valid_ff;
      step_ok        = 1'b0;
      case (in_item_ff.func)
         FUNC_TICK: begin
            if (clock_valid_ff && !at_end) begin
               step_ok = 1'b1;
               if (cur_second_ff < SECOND_LAST) begin
                  cur_second_in = cur_second_ff + 6'd1;
               end else begin
                  cur_second_in = '0;
                  if (cur_minute_ff < MINUTE_LAST) begin
                     cur_minute_in = cur_minute_ff + 6'd1;
                  end else begin
                     cur_minute_in = '0;
                     if (cur_hour_ff < HOUR_LAST) begin
                        cur_hour_in = cur_hour_ff + 5'd1;
                     end else begin
                        cur_hour_in = '0;
                        if (cur_day_ff < cur_len) begin
                           cur_day_in = cur_day_ff + 5'd1;
                        end else begin
                           cur_day_in = 5'd1;
                           if (cur_month_ff < MONTH_LAST) begin
                              cur_month_in = cur_month_ff + 4'd1;
                           end else begin
                              cur_month_in = 4'd1;
                              cur_year_in  = cur_year_ff + 14'd1;
                           end
                        end
                     end
                  end
               end
            end
         end
         FUNC_LOAD: begin
            step_ok        = load_ok;
            clock_valid_in = load_ok;
            if (load_ok) begin
               cur_year_in   = in_item_ff.year;
               cur_month_in  = in_item_ff.month;
               cur_day_in    = in_item_ff.day;
               cur_hour_in   = in_item_ff.hour;
               cur_minute_in = in_item_ff.minute;
               cur_second_in = in_item_ff.second;
            end else begin
               cur_year_in   = '0;
               cur_month_in  = '0;
               cur_day_in    = '0;
               cur_hour_in   = '0;
               cur_minute_in = '0;
               cur_second_in = '0;
            end
         end
         FUNC_WRITE: begin
            if (clock_valid_ff) begin
               case (in_item_ff.field_sel)
                  SEL_DAY: begin
                     step_ok = date_ok(in_item_ff.day, cur_month_ff, cur_year_ff);
                     if (step_ok) cur_day_in = in_item_ff.day;
                  end
                  SEL_MONTH: begin
                     step_ok = date_ok(cur_day_ff, in_item_ff.month, cur_year_ff);
                     if (step_ok) cur_month_in = in_item_ff.month;
                  end
                  SEL_YEAR: begin
                     step_ok = date_ok(cur_day_ff, cur_month_ff, in_item_ff.year);
                     if (step_ok) cur_year_in = in_item_ff.year;
                  end
                  SEL_HOUR: begin
                     step_ok = time_ok(in_item_ff.hour, cur_minute_ff, cur_second_ff);
                     if (step_ok) cur_hour_in = in_item_ff.hour;
                  end
                  SEL_MINUTE: begin
                     step_ok = time_ok(cur_hour_ff, in_item_ff.minute, cur_second_ff);
                     if (step_ok) cur_minute_in = in_item_ff.minute;
                  end
                  SEL_SECOND: begin
                     step_ok = time_ok(cur_hour_ff, cur_minute_ff, in_item_ff.second);
                     if (step_ok) cur_second_in = in_item_ff.second;
                  end
                  default: step_ok = 1'b0;
               endcase
            end
         end
         default: step_ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_year_ff    <= '0;
         cur_month_ff   <= '0;
         cur_day_ff     <= '0;
         cur_hour_ff    <= '0;
         cur_minute_ff  <= '0;
         cur_second_ff  <= '0;
         clock_valid_ff <= 1'b0;
      end else if (fire) begin
         cur_year_ff    <= cur_year_in;
         cur_month_ff   <= cur_month_in;
         cur_day_ff     <= cur_day_in;
         cur_hour_ff    <= cur_hour_in;
         cur_minute_ff  <= cur_minute_in;
         cur_second_ff  <= cur_second_in;
         clock_valid_ff <= clock_valid_in;
      end
   end

   // the clock registers only move on a transfer into the response slot,
   // so they hold the value of the pending response
   assign cur_key = {cur_year_ff, cur_month_ff, cur_day_ff,
                     cur_hour_ff, cur_minute_ff, cur_second_ff};
   assign tgt_key = {tgt_year_ff, tgt_month_ff, tgt_day_ff,
                     tgt_hour_ff, tgt_minute_ff, tgt_second_ff};

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.day_out      = cur_day_ff;
   assign rsp_if.month_out    = cur_month_ff;
   assign rsp_if.year_out     = cur_year_ff;
   assign rsp_if.hour_out     = cur_hour_ff;
   assign rsp_if.minute_out   = cur_minute_ff;
   assign rsp_if.second_out   = cur_second_ff;
   assign rsp_if.time_valid   = clock_valid_ff;
   assign rsp_if.step_ok      = rsp_ok_ff;
   assign rsp_if.after_target = cur_key > tgt_key;
   assign rsp_if.equal_target = cur_key == tgt_key;

   `CCC_ASSERT_NOW(a_invalid_clock_cleared, clock, reset, !clock_valid_ff,
      cur_key == 40'd0, "invalid clock holds a nonzero field")
   `CCC_ASSERT_NOW(a_valid_clock_in_range, clock, reset, clock_valid_ff,
      (cur_month_ff >= 4'd1) && (cur_month_ff <= MONTH_LAST) && (cur_day_ff >= 5'd1) &&
      (cur_year_ff <= YEAR_MAX) && (cur_hour_ff <= HOUR_LAST) &&
      (cur_minute_ff <= MINUTE_LAST) && (cur_second_ff <= SECOND_LAST),
      "valid clock holds an out-of-range field")
   `CCC_ASSERT_NOW(a_ok_needs_valid, clock, reset, rsp_valid_ff && rsp_ok_ff,
      clock_valid_ff, "accepted step left the clock invalid")
   `CCC_ASSERT_NEXT(a_fire_gives_response, clock, reset, fire, rsp_valid_ff,
      "applied command produced no response")

endmodule

// File: verif/calendar_clock_counter_test.sv
// self-checking testbench for the calendar clock counter: directed table, then random phases
`timescale 1ns / 1ps

module calendar_clock_counter_test;
   import cal_clk_pkg::*;

   localparam int CLOCK_HALF   = 2;
   localparam int DRAIN_CYCLES = 6;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 170;
   localparam int NUM_DIRECTED = 26;

   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN   = 2'd3;
   localparam logic [SEL_W-1:0]  SEL_UNKNOWN_LO = 3'd6;
   localparam logic [SEL_W-1:0]  SEL_UNKNOWN_HI = 3'd7;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } calendar_time_type;

   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic                time_valid;
      logic                step_ok;
      logic                after_target;
      logic                equal_target;
   } clock_rsp_type;

   typedef struct {
      req_item_type  cmd;
      logic          typed;
      clock_rsp_type want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cal_clk_req_if req_if ();
   cal_clk_rsp_if rsp_if ();

   calendar_clock_counter u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   calendar_time_type held_time;
   logic              held_valid;
   calendar_time_type target_time;
   clock_rsp_type     pending_clock_rsp [$];
   int                error_count;
   logic              idle_on;
   int                stall_left;

   initial begin
      clock = 1'b0;
   end

   always #(CLOCK_HALF) clock = ~clock;

   initial begin
      #(2_000_000);
      $display("status: fail");
      $finish;
   end

   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                      input logic [YEAR_W-1:0] y);
      int unsigned yr;
      yr = 32'(y);
      case (m)
         MONTH_FEB: days_in_month = ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0)))
                                    ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days_in_month = 5'd30;
         default: days_in_month = 5'd31;
      endcase
   endfunction

   function automatic logic calendar_date_ok(input calendar_time_type t);
      return (t.month >= 1) && (t.month <= 12) && (t.year <= YEAR_MAX) &&
             (t.day >= 1) && (t.day <= days_in_month(t.month, t.year));
   endfunction

   function automatic logic clock_time_ok(input calendar_time_type t);
      return (t.hour <= 23) && (t.minute <= 59) && (t.second <= 59);
   endfunction

   function automatic clock_rsp_type predict_clock_rsp(input req_item_type c);
      calendar_time_type cand;
      logic              ok;
      clock_rsp_type     r;
      ok = 1'b0;
      cand = held_time;
      case (c.func)
         FUNC_TICK: begin
            if (held_valid && !(held_time.year >= YEAR_MAX && held_time.month == MONTH_LAST &&
                held_time.day == DAY_LAST && held_time.hour == HOUR_LAST &&
                held_time.minute == MINUTE_LAST && held_time.second == SECOND_LAST)) begin
               ok = 1'b1;
               if (cand.second < SECOND_LAST) begin
                  cand.second++;
               end else begin
                  cand.second = '0;
                  if (cand.minute < MINUTE_LAST) begin
                     cand.minute++;
                  end else begin
                     cand.minute = '0;
                     if (cand.hour < HOUR_LAST) begin
                        cand.hour++;
                     end else begin
                        cand.hour = '0;
                        if (cand.day < days_in_month(cand.month, cand.year)) begin
                           cand.day++;
                        end else begin
                           cand.day = 5'd1;
                           if (cand.month < MONTH_LAST) begin
                              cand.month++;
                           end else begin
                              cand.month = 4'd1;
                              cand.year++;
                           end
                        end
                     end
                  end
               end
               held_time = cand;
            end
         end
         FUNC_LOAD: begin
            cand = '{c.year, c.month, c.day, c.hour, c.minute, c.second};
            if (calendar_date_ok(cand) && clock_time_ok(cand)) begin
               held_time  = cand;
               held_valid = 1'b1;
               ok = 1'b1;
            end else begin
               held_time  = '0;
               held_valid = 1'b0;
            end
         end
         FUNC_WRITE: begin
            if (held_valid) begin
               case (c.field_sel)
                  SEL_DAY:    cand.day = c.day;
                  SEL_MONTH:  cand.month = c.month;
                  SEL_YEAR:   cand.year = c.year;
                  SEL_HOUR:   cand.hour = c.hour;
                  SEL_MINUTE: cand.minute = c.minute;
                  SEL_SECOND: cand.second = c.second;
                  default: ;
               endcase
               case (c.field_sel)
                  SEL_DAY, SEL_MONTH, SEL_YEAR: ok = calendar_date_ok(cand);
                  SEL_HOUR, SEL_MINUTE, SEL_SECOND: ok = clock_time_ok(cand);
                  default: ok = 1'b0;
               endcase
               if (ok) begin
                  held_time = cand;
               end
            end
         end
         default: ;
      endcase
      r.day          = held_time.day;
      r.month        = held_time.month;
      r.year         = held_time.year;
      r.hour         = held_time.hour;
      r.minute       = held_time.minute;
      r.second       = held_time.second;
      r.time_valid   = held_valid;
      r.step_ok      = ok;
      r.after_target = held_time > target_time;
      r.equal_target = held_time == target_time;
      return r;
   endfunction

   function automatic req_item_type mk_cmd(input logic [FUNC_W-1:0] f,
                                           input logic [SEL_W-1:0] sel,
                                           input int unsigned d, input int unsigned m,
                                           input int unsigned y, input int unsigned h,
                                           input int unsigned mi, input int unsigned s);
      req_item_type c;
      c.func      = f;
      c.field_sel = sel;
      c.day       = DAY_W'(d);
      c.month     = MONTH_W'(m);
      c.year      = YEAR_W'(y);
      c.hour      = HOUR_W'(h);
      c.minute    = MINUTE_W'(mi);
      c.second    = SECOND_W'(s);
      return c;
   endfunction

   function automatic clock_rsp_type mk_rsp(input int unsigned d, input int unsigned m,
                                            input int unsigned y, input int unsigned h,
                                            input int unsigned mi, input int unsigned s,
                                            input int unsigned tv, input int unsigned ok,
                                            input int unsigned af, input int unsigned eq);
      clock_rsp_type r;
      r.day          = DAY_W'(d);
      r.month        = MONTH_W'(m);
      r.year         = YEAR_W'(y);
      r.hour         = HOUR_W'(h);
      r.minute       = MINUTE_W'(mi);
      r.second       = SECOND_W'(s);
      r.time_valid   = 1'(tv);
      r.step_ok      = 1'(ok);
      r.after_target = 1'(af);
      r.equal_target = 1'(eq);
      return r;
   endfunction

   function automatic logic [YEAR_W-1:0] pick_year();
      case ($urandom_range(0, 5))
         0: pick_year = YEAR_W'($urandom_range(0, 9999));
         1: begin
            case ($urandom_range(0, 9))
               0: pick_year = 14'd0;
               1: pick_year = 14'd4;
               2: pick_year = 14'd100;
               3: pick_year = 14'd400;
               4: pick_year = 14'd1900;
               5: pick_year = 14'd2000;
               6: pick_year = 14'd2100;
               7: pick_year = 14'd2400;
               8: pick_year = 14'd9996;
               default: pick_year = 14'd9999;
            endcase
         end
         2: pick_year = YEAR_MAX;
         3: pick_year = (target_time.year <= YEAR_MAX) ? target_time.year : YEAR_MAX;
         default: pick_year = YEAR_W'($urandom_range(1990, 2030));
      endcase
   endfunction

   function automatic calendar_time_type random_valid_time();
      calendar_time_type t;
      logic [DAY_W-1:0]  mlen;
      t.year = pick_year();
      if ($urandom_range(0, 2) == 0) begin
         t.month = ($urandom_range(0, 1) == 0) ? MONTH_LAST : MONTH_FEB;
      end else begin
         t.month = MONTH_W'($urandom_range(1, 12));
      end
      mlen = days_in_month(t.month, t.year);
      t.day    = ($urandom_range(0, 4) < 3) ? DAY_W'(mlen - $urandom_range(0, 1))
                                            : DAY_W'($urandom_range(1, mlen));
      t.hour   = ($urandom_range(0, 1) == 0) ? HOUR_LAST : HOUR_W'($urandom_range(0, 23));
      t.minute = ($urandom_range(0, 1) == 0) ? MINUTE_LAST
                                             : MINUTE_W'($urandom_range(0, 59));
      t.second = ($urandom_range(0, 4) < 3) ? SECOND_W'($urandom_range(55, 59))
                                            : SECOND_W'($urandom_range(0, 59));
      return t;
   endfunction

   function automatic req_item_type random_clock_cmd();
      req_item_type      c;
      logic [63:0]       noise;
      calendar_time_type t;
      int unsigned       kind;
      noise = {$urandom, $urandom};
      c = noise[$bits(req_item_type)-1:0];
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         c.func = FUNC_TICK;
      end else if (kind < 74) begin
         c.func = FUNC_LOAD;
         if (kind < 65) begin
            t = random_valid_time();
         end else if (kind < 68) begin
            t = target_time;
         end else if (kind < 70) begin
            t = '{YEAR_MAX, MONTH_LAST, DAY_LAST, HOUR_LAST, MINUTE_LAST, 6'd55};
            t.second = SECOND_W'($urandom_range(55, 59));
         end else begin
            t = '{c.year, c.month, c.day, c.hour, c.minute, c.second};
         end
         {c.year, c.month, c.day, c.hour, c.minute, c.second} = t;
      end else if (kind < 95) begin
         c.func = FUNC_WRITE;
         c.field_sel = SEL_W'($urandom_range(0, 5));
         if ($urandom_range(0, 1) == 0) begin
            case (c.field_sel)
               SEL_DAY:    c.day = DAY_W'($urandom_range(1, 31));
               SEL_MONTH:  c.month = MONTH_W'($urandom_range(1, 12));
               SEL_YEAR:   c.year = pick_year();
               SEL_HOUR:   c.hour = HOUR_W'($urandom_range(0, 23));
               SEL_MINUTE: c.minute = MINUTE_W'($urandom_range(0, 59));
               default:    c.second = SECOND_W'($urandom_range(0, 59));
            endcase
         end
      end else if ($urandom_range(0, 1) == 0) begin
         c.func = FUNC_UNKNOWN;
      end else begin
         c.func = FUNC_WRITE;
         c.field_sel = ($urandom_range(0, 1) == 0) ? SEL_UNKNOWN_LO : SEL_UNKNOWN_HI;
      end
      return c;
   endfunction

   task automatic send_clock_cmd(input req_item_type c, input logic typed,
                                 input clock_rsp_type want);
      clock_rsp_type pred;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= c.func;
      req_if.field_sel <= c.field_sel;
      req_if.day_in    <= c.day;
      req_if.month_in  <= c.month;
      req_if.year_in   <= c.year;
      req_if.hour_in   <= c.hour;
      req_if.minute_in <= c.minute;
      req_if.second_in <= c.second;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pred = predict_clock_rsp(c);
      pending_clock_rsp.push_back(typed ? want : pred);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_clock_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_target(input calendar_time_type t);
      logic [CSR_DATA_W-1:0] value [6];
      value[CSR_TARGET_YEAR]   = CSR_DATA_W'(t.year);
      value[CSR_TARGET_MONTH]  = CSR_DATA_W'(t.month);
      value[CSR_TARGET_DAY]    = CSR_DATA_W'(t.day);
      value[CSR_TARGET_HOUR]   = CSR_DATA_W'(t.hour);
      value[CSR_TARGET_MINUTE] = CSR_DATA_W'(t.minute);
      value[CSR_TARGET_SECOND] = CSR_DATA_W'(t.second);
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= value[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      target_time = t;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // response side: random stalls, compare each transfer with the oldest expectation
   always @(posedge clock) begin
      clock_rsp_type got;
      clock_rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.day_out, rsp_if.month_out, rsp_if.year_out, rsp_if.hour_out,
                   rsp_if.minute_out, rsp_if.second_out, rsp_if.time_valid,
                   rsp_if.step_ok, rsp_if.after_target, rsp_if.equal_target};
            if (pending_clock_rsp.size() == 0) begin
               $display("%0t ns: unexpected response, expected none actual %h", $time, got);
               error_count++;
            end else begin
               want = pending_clock_rsp.pop_front();
               check_field("day_out", want.day, got.day);
               check_field("month_out", want.month, got.month);
               check_field("year_out", want.year, got.year);
               check_field("hour_out", want.hour, got.hour);
               check_field("minute_out", want.minute, got.minute);
               check_field("second_out", want.second, got.second);
               check_field("time_valid", want.time_valid, got.time_valid);
               check_field("step_ok", want.step_ok, got.step_ok);
               check_field("after_target", want.after_target, got.after_target);
               check_field("equal_target", want.equal_target, got.equal_target);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      stim_row_type      dir_rows [NUM_DIRECTED];
      calendar_time_type t;
      clock_rsp_type     none;
      none             = '0;
      error_count      = 0;
      idle_on          = 1'b1;
      held_time        = '0;
      held_valid       = 1'b0;
      target_time      = '{14'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.func      = FUNC_TICK;
      req_if.field_sel = SEL_DAY;
      req_if.day_in    = '0;
      req_if.month_in  = '0;
      req_if.year_in   = '0;
      req_if.hour_in   = '0;
      req_if.minute_in = '0;
      req_if.second_in = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_rows = '{
         // invalid after reset: tick and write do nothing
         '{mk_cmd(FUNC_TICK, SEL_DAY, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
         '{mk_cmd(FUNC_WRITE, SEL_DAY, 5, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
         // last second of the last year, then saturation
         '{mk_cmd(FUNC_LOAD, SEL_DAY, 31, 12, 9999, 23, 59, 58), 1'b1,
           mk_rsp(31, 12, 9999, 23, 59, 58, 1, 1, 1, 0)},
         '{mk_cmd(FUNC_TICK, SEL_DAY, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(31, 12, 9999, 23, 59, 59, 1, 1, 1, 0)},
         '{mk_cmd(FUNC_TICK, SEL_DAY, 0, 0, 0, 0, 0, 0), 1'b1,
           mk_rsp(31, 12, 9999, 23, 59, 59, 1, 0, 1, 0)},
         // rejected loads clear the clock
         '{mk_cmd(FUNC_LOAD, SEL_DAY, 1, 13, 2000, 0, 0, 0), 1'b1,
           mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
         '{mk_cmd(FUNC_LOAD, SEL_UNKNOWN_HI, 31, 15, 16383, 31, 63, 63), 1'b1,
           mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
         // lowest valid time equals the reset target
         '{mk_cmd(FUNC_LOAD, SEL_DAY, 1, 1, 0, 0, 0, 0), 1'b1,
           mk_rsp(1, 1, 0, 0, 0, 0, 1, 1, 0, 1)},
         // leap year rollovers
         '{mk_cmd(FUNC_LOAD, SEL_DAY, 28, 2, 2024, 23, 59, 59), 1'b0, none},
         '{mk_cmd(FUNC_TICK, SEL_DAY, 0, 0, 0, 0, 0, 0), 1'b0, none},
         '{mk_cmd(FUNC_LOAD, SEL_DAY, 29, 2, 2000, 23, 59, 59), 1'b0, none},
         '{mk_cmd(FUNC_TICK, SEL_DAY, 0, 0, 0, 0, 0, 0), 1'b0, none},
         '{mk_cmd(FUNC_LOAD, SEL_DAY, 29, 2, 1900, 0, 0, 0), 1'b1,
           mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
         // year rollover
         '{mk_cmd(FUNC_LOAD, SEL_DAY, 31, 12, 2023, 23, 59, 59), 1'b0, none},
         '{mk_cmd(FUNC_TICK, SEL_DAY, 0, 0, 0, 0, 0, 0), 1'b0, none},
         // single field writes, accepted and rejected
         '{mk_cmd(FUNC_WRITE, SEL_DAY, 31, 0, 0, 0, 0, 0), 1'b0, none},
         '{mk_cmd(FUNC_WRITE, SEL_MONTH, 0, 2, 0, 0, 0, 0), 1'b0, none},
         '{mk_cmd(FUNC_WRITE, SEL_YEAR, 0, 0, 10000, 0, 0, 0), 1'b0, none},
         '{mk_cmd(FUNC_WRITE, SEL_HOUR, 0, 0, 0, 24, 0, 0), 1'b0, none},
         '{mk_cmd(FUNC_WRITE, SEL_HOUR, 0, 0, 0, 23, 0, 0), 1'b0, none},
         '{mk_cmd(FUNC_WRITE, SEL_MINUTE, 0, 0, 0, 0, 59, 0), 1'b0, none},
         '{mk_cmd(FUNC_WRITE, SEL_SECOND, 0, 0, 0, 0, 0, 60), 1'b0, none},
         '{mk_cmd(FUNC_WRITE, SEL_SECOND, 0, 0, 0, 0, 0, 59), 1'b0, none},
         '{mk_cmd(FUNC_WRITE, SEL_UNKNOWN_LO, 1, 1, 1, 1, 1, 1), 1'b0, none},
         '{mk_cmd(FUNC_UNKNOWN, SEL_DAY, 1, 1, 1, 1, 1, 1), 1'b0, none},
         // month rollover from the written fields
         '{mk_cmd(FUNC_TICK, SEL_DAY, 0, 0, 0, 0, 0, 0), 1'b0, none}
      };
      foreach (dir_rows[i]) begin
         send_clock_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: t = '0;
            1: t = '1;
            2: t = '{YEAR_MAX, MONTH_LAST, DAY_LAST, HOUR_LAST, MINUTE_LAST, SECOND_LAST};
            default: t = random_valid_time();
         endcase
         set_target(t);
         if (phase == NUM_PHASES - 1) begin
            idle_on = 1'b0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == PHASE_ITEMS / 2) begin
               wait_idle();
            end
            send_clock_cmd(random_clock_cmd(), 1'b0, none);
         end
      end

      req_if.valid <= 1'b0;
      while (pending_clock_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
